### sv/ordered_unique_set_core_defines.svh
// Assertion macros used by the port-level checker of the ordered unique set core.
// No dependencies; include once through the guard below.
`ifndef ORDERED_UNIQUE_SET_CORE_DEFINES_SVH
`define ORDERED_UNIQUE_SET_CORE_DEFINES_SVH

// Same-cycle implication, reset disables the check.
`define OUS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ordered_unique_set_core: assertion failed");

// Next-cycle implication, reset disables the check.
`define OUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ordered_unique_set_core: assertion failed");

`endif

### sv/ous_pkg.sv
// Package of the ordered unique set core: key width, default capacity, codes and types.
// Used by the cell, the top level and the checker of the block; depends on nothing.
`timescale 1ns / 1ps

package ous_pkg;

  localparam int KEY_W        = 6;
  localparam int RANK_W       = 4;
  localparam int SUIT_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_APPLY
  } fsm_e;

  typedef logic [KEY_W-1:0] key_t;

  // Command broadcast along the row of cells.
  typedef struct packed {
    cell_op_e op;
    key_t     key;
  } cell_cmd_t;

endpackage

### sv/ous_cell.sv
// One storage cell of the ordered unique set row: holds one key, compares it and shifts.
// Depends on ous_pkg.
`timescale 1ns / 1ps

module ous_cell #(
  parameter int Idx  = 0,
  parameter int IdxW = 6,
  parameter int CntW = 7
) (
  input  logic              clk_i,
  input  ous_pkg::cell_cmd_t cmd_i,
  input  logic [IdxW-1:0]   pos_i,
  input  logic [CntW-1:0]   count_i,
  input  ous_pkg::key_t     next_key_i,
  output ous_pkg::key_t     key_o,
  output logic              match_o
);

  ous_pkg::key_t entry_q;
  ous_pkg::key_t entry_d;
  logic          occupied;

  // Only positions below the count hold live keys.
  assign occupied = CntW'(Idx) < count_i;
  assign match_o  = occupied && (entry_q == cmd_i.key);
  assign key_o    = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      ous_pkg::CELL_WRITE: begin
        if (CntW'(Idx) == count_i) begin
          entry_d = cmd_i.key;
        end
      end
      ous_pkg::CELL_SHIFT: begin
        if (IdxW'(Idx) >= pos_i) begin
          entry_d = next_key_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### sv/ous_locate.sv
// Turns the one-hot match vector of the cell row into a hit flag and a position.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module ous_locate #(
  parameter int Capacity = 64,
  parameter int IdxW     = 6
) (
  input  logic [Capacity-1:0] match_i,
  output logic                hit_o,
  output logic [IdxW-1:0]     pos_o
);

  // Keys are unique, so at most one bit is set and an OR of indices encodes it.
  always_comb begin
    pos_o = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (match_i[i]) begin
        pos_o = pos_o | IdxW'(i);
      end
    end
  end

  assign hit_o = |match_i;

endmodule

### sv/ordered_unique_set_core.sv
// Top level of the ordered unique set core: FSM, count register, result register, cell row.
// Depends on ous_pkg, ous_cell and ous_locate.
`timescale 1ns / 1ps

// The core keeps an insertion-ordered list of up to CAPACITY unique keys, each key
// being a suit and a rank. An insert appends the key unless it is already held; a
// remove deletes the matching entry and closes the gap so that the list stays
// compact. Every accepted item returns exactly one result carrying a status and the
// number of entries held afterwards. An item passes through a search and an apply
// state: in the search state, every cell of the row compares its key with the
// request at once and the matching position is registered; in the apply state, the
// row is updated in parallel (a write at the end of the list, or a one-place shift
// of every entry above the match) and the result is loaded into the output
// register. The next item is accepted in the apply state, as the current item retires
// into the output register, and not before. A result held by a stalled output
// delays the update until the output register can take the new result. No clearing
// pass is needed after reset: the storage is only read below the entry count.
module ordered_unique_set_core #(
  parameter int CAPACITY = ous_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [ous_pkg::SUIT_W-1:0]    suit_i,
  input  logic [ous_pkg::RANK_W-1:0]    rank_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ous_pkg::STATUS_W-1:0]  status_o,
  output logic [ous_pkg::COUNT_W-1:0]   count_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Control state.
  ous_pkg::fsm_e     state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;

  // Request and search results; these need no reset.
  ous_pkg::opcode_e  op_q;
  ous_pkg::key_t     key_q;
  logic              hit_q;
  logic [IDX_W-1:0]  pos_q;
  ous_pkg::status_e  status_q, status_d;
  logic [ous_pkg::COUNT_W-1:0] out_count_q, out_count_d;

  logic              in_accept;
  logic              out_free;
  logic              load_result;
  ous_pkg::cell_cmd_t cmd;

  logic [CAPACITY-1:0] match;
  logic                hit;
  logic [IDX_W-1:0]    pos;
  ous_pkg::key_t       row_key  [CAPACITY];
  ous_pkg::key_t       next_key [CAPACITY];

  // Widened count so that the 7-bit result field can be cut out for any capacity.
  logic [CNT_W+ous_pkg::COUNT_W-1:0] count_wide;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;

  // Sequencer: a new item enters when idle, or in the update cycle that retires
  // the current item into the output register.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    load_result = 1'b0;
    in_stall_o  = 1'b1;
    cmd.op      = ous_pkg::CELL_HOLD;
    cmd.key     = key_q;

    unique case (state_q)
      ous_pkg::FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ous_pkg::FSM_SEARCH;
        end
      end
      ous_pkg::FSM_SEARCH: begin
        state_d = ous_pkg::FSM_APPLY;
      end
      ous_pkg::FSM_APPLY: begin
        if (out_free) begin
          load_result = 1'b1;
          in_stall_o  = 1'b0;
          state_d     = in_valid_i ? ous_pkg::FSM_SEARCH : ous_pkg::FSM_IDLE;
          if (op_q == ous_pkg::OP_INSERT) begin
            // The presence check comes first, so a duplicate wins over a full list.
            if (hit_q) begin
              status_d = ous_pkg::ST_DUPLICATE;
            end else if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ous_pkg::ST_FULL;
            end else begin
              status_d = ous_pkg::ST_INSERTED;
              cmd.op   = ous_pkg::CELL_WRITE;
              count_d  = count_q + CNT_W'(1);
            end
          end else begin
            if (hit_q) begin
              status_d = ous_pkg::ST_REMOVED;
              cmd.op   = ous_pkg::CELL_SHIFT;
              count_d  = count_q - CNT_W'(1);
            end else begin
              status_d = ous_pkg::ST_NOT_FOUND;
            end
          end
        end
      end
      default: begin
        state_d = ous_pkg::FSM_IDLE;
      end
    endcase
  end

  assign count_wide  = {{ous_pkg::COUNT_W{1'b0}}, count_d};
  assign out_count_d = count_wide[ous_pkg::COUNT_W-1:0];
  assign out_valid_d = load_result || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ous_pkg::FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= ous_pkg::opcode_e'(opcode_i);
      key_q <= {suit_i, rank_i};
    end
    if (state_q == ous_pkg::FSM_SEARCH) begin
      hit_q <= hit;
      pos_q <= pos;
    end
    if (load_result) begin
      status_q    <= status_d;
      out_count_q <= out_count_d;
    end
  end

  // The row of cells: each cell takes its upper neighbour's key on a shift; the
  // top cell has no neighbour and feeds back its own key, which is then unused.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i < CAPACITY - 1) begin : g_link
      assign next_key[i] = row_key[i+1];
    end else begin : g_end
      assign next_key[i] = row_key[i];
    end

    ous_cell #(
      .Idx (i),
      .IdxW(IDX_W),
      .CntW(CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .pos_i     (pos_q),
      .count_i   (count_q),
      .next_key_i(next_key[i]),
      .key_o     (row_key[i]),
      .match_o   (match[i])
    );
  end

  ous_locate #(
    .Capacity(CAPACITY),
    .IdxW    (IDX_W)
  ) u_locate (
    .match_i(match),
    .hit_o  (hit),
    .pos_o  (pos)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = out_count_q;

endmodule

### sv/ous_checker.sv
// Port-level checks of the ordered unique set core, bound to its top level.
// Depends on ous_pkg and ordered_unique_set_core_defines.svh.
`timescale 1ns / 1ps
`include "ordered_unique_set_core_defines.svh"

module ous_checker #(
  parameter int CAPACITY = ous_pkg::CAPACITY_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ous_pkg::STATUS_W-1:0] status_o,
  input logic [ous_pkg::COUNT_W-1:0]  count_o
);

  localparam logic [ous_pkg::COUNT_W-1:0] CAP_FIELD = ous_pkg::COUNT_W'(CAPACITY);
  localparam logic                        CAP_WRAPS = (CAPACITY > 127);

  logic                                          out_held;
  logic [ous_pkg::STATUS_W+ous_pkg::COUNT_W-1:0] out_word;
  logic                                          count_ok;
  logic                                          full_seen;
  logic                                          ins_seen;

  assign out_held  = out_valid_o && out_stall_i;
  assign out_word  = {status_o, count_o};
  assign count_ok  = CAP_WRAPS || (count_o <= CAP_FIELD);
  assign full_seen = out_valid_o && (status_o == ous_pkg::ST_FULL);
  assign ins_seen  = out_valid_o && (status_o == ous_pkg::ST_INSERTED);

  // A held result stays put while the output is stalled.
  `OUS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word))

  // Only the five defined status codes are reported.
  `OUS_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o, status_o <= ous_pkg::ST_FULL)

  // The count never exceeds the capacity.
  `OUS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, out_valid_o, count_ok)

  // A rejection for a full list reports the full count.
  `OUS_ASSERT_IMP(a_full_count, clk_i, rst_ni, full_seen, count_o == CAP_FIELD)

  // A successful insert always leaves at least one entry.
  `OUS_ASSERT_IMP(a_insert_nonzero, clk_i, rst_ni, ins_seen, CAP_WRAPS || (count_o != '0))

endmodule

bind ordered_unique_set_core ous_checker #(.CAPACITY(CAPACITY)) u_ous_checker (.*);
